### rtl/srr_pkg.sv
package srr_pkg;

    // sequence space, receive window and stored payload width
    localparam int SEQ_SPACE    = 8;
    localparam int WINDOW       = 3;
    localparam int PAYLOAD_BITS = 64;
    localparam int QUEUE_DEPTH  = 2;

    // fixed port widths
    localparam int SEQ_PORT_W     = 3;
    localparam int PAYLOAD_PORT_W = 64;

    localparam int SEQ_W = $clog2(SEQ_SPACE);
    localparam int CNT_W = $clog2(WINDOW + 1);

    typedef logic [SEQ_W-1:0]        seq_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [PAYLOAD_BITS-1:0] data_t;

    typedef enum logic
    {
        RES_ACK     = 1'b0,
        RES_DELIVER = 1'b1
    } res_kind_t;

    typedef enum logic [1:0]
    {
        B_IDLE,
        B_ACK,
        B_DLV
    } back_state_t;

    // work for the back end: acknowledge seq, optionally store, then deliver count slots
    typedef struct packed
    {
        seq_t  seq;
        logic  store;
        cnt_t  count;
        data_t data;
    } srr_cmd_t;

    // port sequence number reduced into the sequence space
    function automatic seq_t seq_mod(input logic [SEQ_PORT_W-1:0] x);
        logic [SEQ_W+3:0] w;
        w = (SEQ_W+4)'(x);
        if (w >= (SEQ_W+4)'(SEQ_SPACE))
        begin
            w = w - (SEQ_W+4)'(SEQ_SPACE);
        end
        return w[SEQ_W-1:0];
    endfunction

    // (a + b) mod SEQ_SPACE for operands already in range
    function automatic seq_t add_mod(input seq_t a, input seq_t b);
        logic [SEQ_W:0] w;
        w = {1'b0, a} + {1'b0, b};
        if (w >= (SEQ_W+1)'(SEQ_SPACE))
        begin
            w = w - (SEQ_W+1)'(SEQ_SPACE);
        end
        return w[SEQ_W-1:0];
    endfunction

    // (a - b) mod SEQ_SPACE for operands already in range
    function automatic seq_t sub_mod(input seq_t a, input seq_t b);
        logic [SEQ_W:0] w;
        w = {1'b0, a} - {1'b0, b};
        if (a < b)
        begin
            w = w + (SEQ_W+1)'(SEQ_SPACE);
        end
        return w[SEQ_W-1:0];
    endfunction

    // sequence slot as the 3-bit acknowledgement number
    function automatic logic [SEQ_PORT_W-1:0] ack_of(input seq_t s);
        logic [SEQ_W+SEQ_PORT_W-1:0] w;
        w = (SEQ_W+SEQ_PORT_W)'(s);
        return w[SEQ_PORT_W-1:0];
    endfunction

    // stored payload zero-extended to the port width
    function automatic logic [PAYLOAD_PORT_W-1:0] widen_payload(input data_t d);
        logic [PAYLOAD_PORT_W-1:0] w;
        w = '0;
        w[PAYLOAD_BITS-1:0] = d;
        return w;
    endfunction

endpackage

### rtl/selective_repeat_receiver.sv
// Selective-repeat ARQ receiver, sequence numbers modulo 8, receive window of 3.
// Each packet beat on the pkt channel is accepted whenever the two-entry
// command queue has room. Bad-checksum, held-duplicate and out-of-window
// packets get no result, but a good one up to three slots behind the base is
// acknowledged again. A good new packet yields one acknowledgement on the res
// channel, followed (when it fills the slot at the window base) by up to three
// in-order deliveries; last marks the final beat of each packet. The idle back
// end takes a command from the queue, then emits one result per cycle while
// res_ready allows (single result port, one-read-per-cycle reorder buffer) and
// takes no new command until the last result is loaded. The window base resets
// to 1 and all received marks clear at reset; the buffer needs no clearing pass.
module selective_repeat_receiver
    import srr_pkg::*;
    #(
        parameter int QUEUE_ENTRIES = QUEUE_DEPTH
    )
    (
        input  logic                      clk,
        input  logic                      rst_n,
        input  logic                      pkt_valid,
        output logic                      pkt_ready,
        input  logic [SEQ_PORT_W-1:0]     seq_number,
        input  logic                      checksum_ok,
        input  logic [PAYLOAD_PORT_W-1:0] payload,
        output logic                      res_valid,
        input  logic                      res_ready,
        output logic                      result_kind,
        output logic [SEQ_PORT_W-1:0]     ack_number,
        output logic [PAYLOAD_PORT_W-1:0] delivered_payload,
        output logic                      last
    );

    srr_cmd_t front_cmd, back_cmd;
    logic     front_valid, front_ready;
    logic     back_valid, back_ready;

    // window tracking and classification
    srr_front u_front
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .pkt_valid   (pkt_valid),
            .pkt_ready   (pkt_ready),
            .seq_number  (seq_number),
            .checksum_ok (checksum_ok),
            .payload     (payload),
            .cmd_valid   (front_valid),
            .cmd_ready   (front_ready),
            .cmd         (front_cmd)
        );

    // command queue between the two halves
    srr_fifo
        #(
            .DEPTH (QUEUE_ENTRIES)
        )
        u_queue
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .push_valid (front_valid),
            .push_ready (front_ready),
            .push_data  (front_cmd),
            .pop_valid  (back_valid),
            .pop_ready  (back_ready),
            .pop_data   (back_cmd)
        );

    // acknowledgement and delivery sequencing
    srr_back u_back
        (
            .clk               (clk),
            .rst_n             (rst_n),
            .cmd_valid         (back_valid),
            .cmd_ready         (back_ready),
            .cmd               (back_cmd),
            .res_valid         (res_valid),
            .res_ready         (res_ready),
            .result_kind       (result_kind),
            .ack_number        (ack_number),
            .delivered_payload (delivered_payload),
            .last              (last)
        );

endmodule

### rtl/srr_ram.sv
module srr_ram
    #(
        parameter int WIDTH = 8,
        parameter int DEPTH = 8
    )
    (
        input  logic                     clk,
        input  logic                     wr_en,
        input  logic [$clog2(DEPTH)-1:0] wr_addr,
        input  logic [WIDTH-1:0]         wr_data,
        input  logic                     rd_en,
        input  logic [$clog2(DEPTH)-1:0] rd_addr,
        output logic [WIDTH-1:0]         rd_data
    );

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/srr_fifo.sv
module srr_fifo
    import srr_pkg::*;
    #(
        parameter int DEPTH = QUEUE_DEPTH
    )
    (
        input  logic     clk,
        input  logic     rst_n,
        input  logic     push_valid,
        output logic     push_ready,
        input  srr_cmd_t push_data,
        output logic     pop_valid,
        input  logic     pop_ready,
        output srr_cmd_t pop_data
    );

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    srr_cmd_t          entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              do_push, do_pop;

    assign push_ready = (fill_reg != FILL_W'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/srr_front.sv
module srr_front
    import srr_pkg::*;
    (
        input  logic                      clk,
        input  logic                      rst_n,
        input  logic                      pkt_valid,
        output logic                      pkt_ready,
        input  logic [SEQ_PORT_W-1:0]     seq_number,
        input  logic                      checksum_ok,
        input  logic [PAYLOAD_PORT_W-1:0] payload,
        output logic                      cmd_valid,
        input  logic                      cmd_ready,
        output srr_cmd_t                  cmd
    );

    seq_t                 base_reg, base_next;
    logic [SEQ_SPACE-1:0] marks_reg, marks_next;

    seq_t                 seq, ahead, behind, slot;
    logic                 in_window, in_behind, is_new, do_ack, store;
    logic                 chain;
    logic [SEQ_SPACE-1:0] marks_set;
    cnt_t                 count;
    logic                 accept;

    assign pkt_ready = cmd_ready;
    assign accept    = pkt_valid && pkt_ready;

    // classify the beat against the window and work out the delivery run
    always_comb
    begin
        seq       = seq_mod(seq_number);
        ahead     = sub_mod(seq, base_reg);
        behind    = sub_mod(base_reg, seq);
        in_window = int'(ahead) < WINDOW;
        in_behind = (behind != '0) && (int'(behind) <= WINDOW);
        is_new    = !in_behind && in_window && !marks_reg[seq];
        do_ack    = checksum_ok && (in_behind || is_new);
        store     = checksum_ok && is_new;

        marks_set = marks_reg;
        if (store)
        begin
            marks_set[seq] = 1'b1;
        end

        // consecutive marked slots from the base, at most one window
        marks_next = marks_set;
        count      = '0;
        chain      = store && (seq == base_reg);
        slot       = base_reg;
        for (int i = 0; i < WINDOW; i++)
        begin
            slot  = add_mod(base_reg, seq_t'(i));
            chain = chain && marks_set[slot];
            if (chain)
            begin
                count            = cnt_t'(count + 1'b1);
                marks_next[slot] = 1'b0;
            end
        end
        base_next = add_mod(base_reg, seq_t'(count));

        cmd.seq   = seq;
        cmd.store = store;
        cmd.count = count;
        cmd.data  = payload[PAYLOAD_BITS-1:0];
    end

    assign cmd_valid = pkt_valid && do_ack;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= seq_t'(1 % SEQ_SPACE);
            marks_reg <= '0;
        end
        else if (accept)
        begin
            base_reg  <= base_next;
            marks_reg <= marks_next;
        end
    end

endmodule

### rtl/srr_back.sv
module srr_back
    import srr_pkg::*;
    (
        input  logic                      clk,
        input  logic                      rst_n,
        input  logic                      cmd_valid,
        output logic                      cmd_ready,
        input  srr_cmd_t                  cmd,
        output logic                      res_valid,
        input  logic                      res_ready,
        output logic                      result_kind,
        output logic [SEQ_PORT_W-1:0]     ack_number,
        output logic [PAYLOAD_PORT_W-1:0] delivered_payload,
        output logic                      last
    );

    back_state_t state_reg, state_next;
    srr_cmd_t    cmd_reg, cmd_next;
    cnt_t        rem_reg, rem_next;
    seq_t        rd_ptr_reg, rd_ptr_next;
    logic        first_reg, first_next;

    logic                      res_valid_reg, res_valid_next;
    res_kind_t                 res_kind_reg, res_kind_next;
    logic [SEQ_PORT_W-1:0]     ack_reg, ack_next;
    logic [PAYLOAD_PORT_W-1:0] data_reg, data_next;
    logic                      last_reg, last_next;

    logic  out_free, load;
    logic  ram_wr_en, ram_rd_en;
    seq_t  ram_rd_addr;
    data_t ram_rd_data;

    assign out_free  = !res_valid_reg || res_ready;
    assign cmd_ready = (state_reg == B_IDLE);

    // reorder buffer, written with each stored beat and read for the delivery run
    srr_ram
        #(
            .WIDTH (PAYLOAD_BITS),
            .DEPTH (SEQ_SPACE)
        )
        u_buf
        (
            .clk     (clk),
            .wr_en   (ram_wr_en),
            .wr_addr (cmd_reg.seq),
            .wr_data (cmd_reg.data),
            .rd_en   (ram_rd_en),
            .rd_addr (ram_rd_addr),
            .rd_data (ram_rd_data)
        );

    // sequencer: acknowledge, then deliver the run one beat a cycle while the output is free
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        rem_next      = rem_reg;
        rd_ptr_next   = rd_ptr_reg;
        first_next    = first_reg;
        load          = 1'b0;
        res_kind_next = res_kind_reg;
        ack_next      = ack_reg;
        data_next     = data_reg;
        last_next     = last_reg;
        ram_wr_en     = 1'b0;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = rd_ptr_reg;

        unique case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    state_next = B_ACK;
                end
            end
            B_ACK:
            begin
                if (out_free)
                begin
                    load          = 1'b1;
                    res_kind_next = RES_ACK;
                    ack_next      = ack_of(cmd_reg.seq);
                    data_next     = '0;
                    last_next     = (cmd_reg.count == '0);
                    ram_wr_en     = cmd_reg.store;
                    rem_next      = cmd_reg.count;
                    first_next    = 1'b1;
                    // second slot of the run is fetched ahead; the first is this beat's payload
                    if (cmd_reg.count > cnt_t'(1))
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = add_mod(cmd_reg.seq, seq_t'(1));
                        rd_ptr_next = add_mod(cmd_reg.seq, seq_t'(2));
                    end
                    state_next = (cmd_reg.count == '0) ? B_IDLE : B_DLV;
                end
            end
            B_DLV:
            begin
                if (out_free)
                begin
                    load          = 1'b1;
                    res_kind_next = RES_DELIVER;
                    ack_next      = '0;
                    data_next     = first_reg ? widen_payload(cmd_reg.data)
                                              : widen_payload(ram_rd_data);
                    last_next     = (rem_reg == cnt_t'(1));
                    rem_next      = rem_reg - 1'b1;
                    first_next    = 1'b0;
                    if (!first_reg && (rem_reg > cnt_t'(1)))
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = rd_ptr_reg;
                        rd_ptr_next = add_mod(rd_ptr_reg, seq_t'(1));
                    end
                    if (rem_reg == cnt_t'(1))
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        if (load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            rem_reg       <= '0;
            first_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rem_reg       <= rem_next;
            first_reg     <= first_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        rd_ptr_reg   <= rd_ptr_next;
        res_kind_reg <= res_kind_next;
        ack_reg      <= ack_next;
        data_reg     <= data_next;
        last_reg     <= last_next;
    end

    assign res_valid         = res_valid_reg;
    assign result_kind       = res_kind_reg;
    assign ack_number        = ack_reg;
    assign delivered_payload = data_reg;
    assign last              = last_reg;

    // a packet's results always open with its acknowledgement
    a_ack_first: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_ready && last_reg)
        |=> (!res_valid_reg || res_kind_reg == RES_ACK))
        else $error("result after a last beat is not an acknowledgement");

    // a run never pauses between beats once the previous one is taken
    a_run_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_ready && !last_reg)
        |=> (res_valid_reg && res_kind_reg == RES_DELIVER))
        else $error("delivery run broken after a non-last beat");

    // delivering with nothing left to deliver
    a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DLV) |-> (rem_reg != '0))
        else $error("delivery state with empty run");

    // the look-ahead read must never hit the slot being written
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_wr_en && ram_rd_en) |-> (ram_rd_addr != cmd_reg.seq))
        else $error("buffer read and write to the same slot");

endmodule
